>>> design/glr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glr_pkg
// Shared constants and types of the gradient line rasteriser.
// ----------------------------------------------------------------------------
package glr_pkg;

    localparam int COORD_BITS_DEF = 12;   // default coordinate width
    localparam int COLOR_BITS     = 32;   // packed RGBA
    localparam int CHAN_BITS      = 8;    // one colour channel
    localparam int NUM_CHANS      = COLOR_BITS / CHAN_BITS;
    localparam int CHAN_IDX_BITS  = $clog2(NUM_CHANS);
    localparam int QBIT_BITS      = $clog2(CHAN_BITS);

    // command codes (slave tuser)
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // sequencer to line walker
    typedef struct packed {
        logic load;      // latch new endpoints
        logic advance;   // emit current pixel, move cursor
    } walk_ctrl_t;

endpackage : glr_pkg
`default_nettype wire

>>> design/glr_blend_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glr_blend_unit
// Shared multiply / restoring-divide unit: c = a + (b-a)*num/den per channel,
// one channel after another, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module glr_blend_unit #(
    parameter int COORD_BITS = glr_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [glr_pkg::COLOR_BITS-1:0] color_from,
    input  logic [glr_pkg::COLOR_BITS-1:0] color_to,
    input  logic [COORD_BITS-1:0]          num,
    input  logic [COORD_BITS-1:0]          den,
    output logic                           done,
    output logic [glr_pkg::COLOR_BITS-1:0] color
);
    import glr_pkg::*;

    localparam int PW = COORD_BITS + CHAN_BITS;   // product / remainder width

    typedef enum logic [2:0] {
        P_IDLE = 3'b001,
        P_MUL  = 3'b010,
        P_DIV  = 3'b100
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [CHAN_IDX_BITS-1:0]    chan_reg;
    logic [QBIT_BITS-1:0]        bit_reg;
    logic [PW-1:0]               rem_reg;
    logic [CHAN_BITS-1:0]        quo_reg;
    logic                        neg_reg;
    logic [COLOR_BITS-1:0]       color_reg;
    logic                        done_reg;

    logic [CHAN_IDX_BITS+QBIT_BITS-1:0] chan_base;
    logic [CHAN_BITS-1:0]        chan_a;
    logic [CHAN_BITS-1:0]        chan_b;
    logic                        chan_neg;
    logic [CHAN_BITS-1:0]        chan_mag;
    logic [PW-1:0]               den_shift;
    logic                        fits;
    logic [CHAN_BITS-1:0]        quo_final;
    logic [CHAN_BITS-1:0]        chan_res;
    logic                        last_bit;
    logic                        last_chan;

    always_comb
    begin
        chan_base = {chan_reg, {QBIT_BITS{1'b0}}};
        chan_a    = color_from[chan_base +: CHAN_BITS];
        chan_b    = color_to[chan_base +: CHAN_BITS];
        chan_neg  = chan_b < chan_a;
        chan_mag  = chan_neg ? (chan_a - chan_b) : (chan_b - chan_a);
        den_shift = PW'(den) << bit_reg;
        fits      = rem_reg >= den_shift;
        quo_final = fits ? (quo_reg | (CHAN_BITS'(1) << bit_reg)) : quo_reg;
        // zero span only for a single-point line: keep the start colour
        if (den == '0)
        begin
            chan_res = chan_a;
        end
        else if (neg_reg)
        begin
            chan_res = chan_a - quo_final;
        end
        else
        begin
            chan_res = chan_a + quo_final;
        end
        last_bit  = bit_reg == '0;
        last_chan = chan_reg == CHAN_IDX_BITS'(NUM_CHANS - 1);
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    phase_next = P_MUL;
                end
            end
            P_MUL:
            begin
                phase_next = P_DIV;
            end
            P_DIV:
            begin
                if (last_bit)
                begin
                    phase_next = last_chan ? P_IDLE : P_MUL;
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            chan_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == P_DIV) && last_bit && last_chan;
            if (phase_reg == P_IDLE && start)
            begin
                chan_reg <= '0;
            end
            else if (phase_reg == P_DIV && last_bit)
            begin
                chan_reg <= chan_reg + CHAN_IDX_BITS'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            P_MUL:
            begin
                rem_reg <= PW'(chan_mag) * PW'(num);
                neg_reg <= chan_neg;
                quo_reg <= '0;
                bit_reg <= QBIT_BITS'(CHAN_BITS - 1);
            end
            P_DIV:
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - den_shift;
                end
                quo_reg <= quo_final;
                bit_reg <= bit_reg - QBIT_BITS'(1);
                if (last_bit)
                begin
                    color_reg[chan_base +: CHAN_BITS] <= chan_res;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done  = done_reg;
    assign color = color_reg;

endmodule : glr_blend_unit
`default_nettype wire

>>> design/glr_line_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glr_line_walker
// All-octant Bresenham stepper; latches the pixel and its gradient
// progress (num over den) on every advance.
// ----------------------------------------------------------------------------
module glr_line_walker #(
    parameter int COORD_BITS = glr_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  glr_pkg::walk_ctrl_t           ctrl,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    output logic                          active,
    output logic [COORD_BITS-1:0]         pixel_x,
    output logic [COORD_BITS-1:0]         pixel_y,
    output logic                          last,
    output logic [COORD_BITS-1:0]         num,
    output logic [COORD_BITS-1:0]         den
);
    import glr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = CB + 3;          // error term width

    logic                 active_reg;
    logic signed [CB-1:0] cursor_x_reg, cursor_y_reg;
    logic signed [CB-1:0] origin_x_reg, origin_y_reg;
    logic signed [CB-1:0] target_x_reg, target_y_reg;
    logic [CB-1:0]        span_x_reg, span_y_reg;
    logic                 step_x_neg_reg, step_y_neg_reg;
    logic signed [EW-1:0] error_reg;
    logic [CB-1:0]        pixel_x_reg, pixel_y_reg;
    logic                 last_reg;
    logic [CB-1:0]        num_reg, den_reg;

    logic signed [CB:0]   ld_dx, ld_dy;
    logic [CB-1:0]        ld_span_x, ld_span_y;
    logic signed [CB:0]   prog_x, prog_y;
    logic [CB-1:0]        prog_abs_x, prog_abs_y;
    logic signed [EW-1:0] sx_e, sy_e;
    logic signed [EW:0]   sx_w, nsy_w;
    logic signed [EW:0]   e2, e2a;
    logic                 x_move, x_hit, done_x;
    logic                 y_move, y_hit, done_y;
    logic signed [EW-1:0] err_a, err_b;

    always_comb
    begin
        // load: spans and initial error
        ld_dx     = $signed({end_x[CB-1], end_x}) - $signed({start_x[CB-1], start_x});
        ld_dy     = $signed({end_y[CB-1], end_y}) - $signed({start_y[CB-1], start_y});
        ld_span_x = ld_dx[CB] ? CB'(-ld_dx) : ld_dx[CB-1:0];
        ld_span_y = ld_dy[CB] ? CB'(-ld_dy) : ld_dy[CB-1:0];

        // gradient progress of the current pixel
        prog_x     = $signed({cursor_x_reg[CB-1], cursor_x_reg})
                   - $signed({origin_x_reg[CB-1], origin_x_reg});
        prog_y     = $signed({cursor_y_reg[CB-1], cursor_y_reg})
                   - $signed({origin_y_reg[CB-1], origin_y_reg});
        prog_abs_x = prog_x[CB] ? CB'(-prog_x) : prog_x[CB-1:0];
        prog_abs_y = prog_y[CB] ? CB'(-prog_y) : prog_y[CB-1:0];

        // Bresenham step, x move then y move on the updated error
        sx_e   = $signed({{(EW-CB){1'b0}}, span_x_reg});
        sy_e   = $signed({{(EW-CB){1'b0}}, span_y_reg});
        sx_w   = $signed({{(EW+1-CB){1'b0}}, span_x_reg});
        nsy_w  = -$signed({{(EW+1-CB){1'b0}}, span_y_reg});
        e2     = $signed({error_reg, 1'b0});
        x_move = e2 >= nsy_w;
        x_hit  = cursor_x_reg == target_x_reg;
        done_x = x_move && x_hit;
        err_a  = (x_move && !x_hit) ? (error_reg - sy_e) : error_reg;
        e2a    = $signed({err_a, 1'b0});
        y_move = !done_x && (e2a <= sx_w);
        y_hit  = cursor_y_reg == target_y_reg;
        done_y = y_move && y_hit;
        err_b  = (y_move && !y_hit) ? (err_a + sx_e) : err_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            active_reg <= 1'b1;
        end
        else if (ctrl.advance && (done_x || done_y))
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            origin_x_reg   <= start_x;
            origin_y_reg   <= start_y;
            target_x_reg   <= end_x;
            target_y_reg   <= end_y;
            cursor_x_reg   <= start_x;
            cursor_y_reg   <= start_y;
            span_x_reg     <= ld_span_x;
            span_y_reg     <= ld_span_y;
            step_x_neg_reg <= !(start_x < end_x);
            step_y_neg_reg <= !(start_y < end_y);
            error_reg      <= $signed({{(EW-CB){1'b0}}, ld_span_x})
                            - $signed({{(EW-CB){1'b0}}, ld_span_y});
        end
        else if (ctrl.advance)
        begin
            pixel_x_reg <= cursor_x_reg;
            pixel_y_reg <= cursor_y_reg;
            last_reg    <= done_x || done_y;
            if (span_x_reg != '0)
            begin
                num_reg <= prog_abs_x;
                den_reg <= span_x_reg;
            end
            else
            begin
                num_reg <= prog_abs_y;
                den_reg <= span_y_reg;
            end
            error_reg <= err_b;
            if (x_move && !x_hit)
            begin
                cursor_x_reg <= step_x_neg_reg ? cursor_x_reg - CB'(1)
                                               : cursor_x_reg + CB'(1);
            end
            if (y_move && !y_hit)
            begin
                cursor_y_reg <= step_y_neg_reg ? cursor_y_reg - CB'(1)
                                               : cursor_y_reg + CB'(1);
            end
        end
    end

    assign active  = active_reg;
    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;
    assign last    = last_reg;
    assign num     = num_reg;
    assign den     = den_reg;

endmodule : glr_line_walker
`default_nettype wire

>>> design/gradient_line_rasterizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_line_rasterizer_top
// Bresenham line rasteriser with a linear per-pixel RGBA gradient.
// ----------------------------------------------------------------------------
// A start item (tuser = 0) loads both endpoints and colours and is taken with
// no result; s_tready stays high. A step item (tuser = 1) while a line is
// active produces one pixel: its coordinates, its colour and tlast on the
// final pixel. A step with no active line is taken and dropped, and a start
// during a line simply abandons it. For each pixel the four colour channels go
// one after another through a single multiplier and restoring divider, a
// multiply and then eight quotient bits per channel; the completion flag is
// then registered and the output register loaded. s_tready is low while the
// pixel is worked on, and stays low for longer while the previous pixel is
// still held in the output register; the finished pixel sits in the output
// register while the next item is taken. Colour per channel is
// a + (b-a)*num/den, truncated towards zero, num/den being the x progress over
// the x span (y for vertical lines); a single-point line takes the start
// colour.
// ----------------------------------------------------------------------------
module gradient_line_rasterizer_top #(
    parameter int COORD_BITS = glr_pkg::COORD_BITS_DEF,
    localparam int S_DATA_BITS = ((4 * COORD_BITS + 2 * glr_pkg::COLOR_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS = ((2 * COORD_BITS + glr_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // start_x, start_y, end_x, end_y, start_color, end_color (lowest bits first)
    input  logic [S_DATA_BITS-1:0] s_tdata,
    // command
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // pixel_x, pixel_y, pixel_color (lowest bits first), zero padded
    output logic [M_DATA_BITS-1:0] m_tdata,
    output logic                   m_tlast
);
    import glr_pkg::*;

    localparam int CB = COORD_BITS;

    // sequencer
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,   // ready for an item
        S_BLEND = 3'b010,   // blend unit working on the pixel colour
        S_OUT   = 3'b100    // waiting for the output register to free up
    } state_t;

    state_t                  state_reg, state_next;
    logic                    m_tvalid_reg;
    logic [M_DATA_BITS-1:0]  m_tdata_reg;
    logic                    m_tlast_reg;

    logic                    in_accept;
    walk_ctrl_t              walk_ctrl;
    logic                    walk_active;
    logic [CB-1:0]           pix_x, pix_y;
    logic                    pix_last;
    logic [CB-1:0]           grad_num, grad_den;
    logic                    blend_done;
    logic [COLOR_BITS-1:0]   blend_color;
    logic                    out_free;
    logic                    out_load;

    logic signed [CB-1:0]    f_start_x, f_start_y, f_end_x, f_end_y;
    logic [COLOR_BITS-1:0]   f_start_color, f_end_color;

    // unpack the input item
    assign f_start_x     = s_tdata[CB-1:0];
    assign f_start_y     = s_tdata[2*CB-1:CB];
    assign f_end_x       = s_tdata[3*CB-1:2*CB];
    assign f_end_y       = s_tdata[4*CB-1:3*CB];
    assign f_start_color = s_tdata[4*CB+COLOR_BITS-1:4*CB];
    assign f_end_color   = s_tdata[4*CB+2*COLOR_BITS-1:4*CB+COLOR_BITS];

    assign s_tready  = state_reg == S_IDLE;
    assign in_accept = s_tvalid && s_tready;

    assign walk_ctrl.load    = in_accept && (s_tuser == CMD_START);
    assign walk_ctrl.advance = in_accept && (s_tuser == CMD_STEP) && walk_active;

    // the output register is free once its item has gone or is going now
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_OUT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (walk_ctrl.advance)
                begin
                    state_next = S_BLEND;
                end
            end
            S_BLEND:
            begin
                if (blend_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= M_DATA_BITS'({blend_color, pix_y, pix_x});
            m_tlast_reg <= pix_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    glr_line_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (walk_ctrl),
        .start_x (f_start_x),
        .start_y (f_start_y),
        .end_x   (f_end_x),
        .end_y   (f_end_y),
        .active  (walk_active),
        .pixel_x (pix_x),
        .pixel_y (pix_y),
        .last    (pix_last),
        .num     (grad_num),
        .den     (grad_den)
    );

    // colours are latched alongside the endpoints; the unit reads them per pixel
    logic [COLOR_BITS-1:0] color_from_reg, color_to_reg;

    always_ff @(posedge clk)
    begin
        if (walk_ctrl.load)
        begin
            color_from_reg <= f_start_color;
            color_to_reg   <= f_end_color;
        end
    end

    glr_blend_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (walk_ctrl.advance),
        .color_from (color_from_reg),
        .color_to   (color_to_reg),
        .num        (grad_num),
        .den        (grad_den),
        .done       (blend_done),
        .color      (blend_color)
    );

endmodule : gradient_line_rasterizer_top
`default_nettype wire

>>> design/glr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glr_checker
// Port-level checks of the rasteriser, bound to the top level.
// ----------------------------------------------------------------------------
module glr_checker #(
    parameter int COORD_BITS = glr_pkg::COORD_BITS_DEF,
    localparam int S_DATA_BITS = ((4 * COORD_BITS + 2 * glr_pkg::COLOR_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS = ((2 * COORD_BITS + glr_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [S_DATA_BITS-1:0] s_tdata,
    input logic                   s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_DATA_BITS-1:0] m_tdata,
    input logic                   m_tlast
);
    import glr_pkg::*;

    logic step_item;
    assign step_item = s_tvalid && s_tready && (s_tuser == CMD_STEP) && (s_tdata == s_tdata);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // the block only goes busy on a step item
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(step_item))
        else $error("tready dropped without an accepted step");

    // a new result only appears at the end of a busy period
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

    // a busy period always ends with a result presented
    a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) |-> m_tvalid)
        else $error("busy period ended without a result");

endmodule : glr_checker

bind gradient_line_rasterizer_top glr_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);
`default_nettype wire
